### hdl/skc_pkg.sv
// ----------------------------------------------------------------------------
// skc_pkg - shared types and constants for the sorted key set table
// Sizes, operation and status codes, and the command broadcast to the cells.
// ----------------------------------------------------------------------------
package skc_pkg;

  localparam int DEPTH = 16;
  localparam int KEY_W = 32;
  localparam int POS_W = 4;
  localparam int OUT_CNT_W = 5;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_FIND   = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_READ   = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_DUP      = 3'd1;
  localparam logic [2:0] ST_NOTFOUND = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_RANGE    = 3'd4;

  typedef struct packed {
    logic                    ins;
    logic                    rem;
    logic [CNT_W-1:0]        at;
    logic signed [KEY_W-1:0] key;
  } cell_cmd_t;

endpackage

### hdl/skc_if.sv
// ----------------------------------------------------------------------------
// skc_if - request and response channels of the sorted key set table
// Valid/ready channels; a request moves at an edge with valid and ready high.
// ----------------------------------------------------------------------------
interface skc_req_if;
  logic                    valid;
  logic                    ready;
  logic [1:0]              opcode;
  logic signed [31:0]      key;
  logic [3:0]              position;

  modport source (output valid, output opcode, output key, output position, input ready);
  modport sink   (input valid, input opcode, input key, input position, output ready);
endinterface

interface skc_rsp_if;
  logic                    valid;
  logic                    ready;
  logic [2:0]              status;
  logic signed [31:0]      key_out;
  logic [3:0]              key_position;
  logic [4:0]              entry_count;

  modport source (output valid, output status, output key_out, output key_position,
                  output entry_count, input ready);
  modport sink   (input valid, input status, input key_out, input key_position,
                  input entry_count, output ready);
endinterface

### hdl/skc_cell.sv
// ----------------------------------------------------------------------------
// skc_cell - one slot of the sorted key chain
// Holds one key, compares it with the probe, shifts with its neighbors.
// ----------------------------------------------------------------------------
module skc_cell (
  input  logic                           clk,
  input  logic [skc_pkg::IDX_W-1:0]      idx,
  input  skc_pkg::cell_cmd_t             cmd,
  input  logic signed [skc_pkg::KEY_W-1:0] probe,
  input  logic signed [skc_pkg::KEY_W-1:0] below_key,
  input  logic signed [skc_pkg::KEY_W-1:0] above_key,
  output logic signed [skc_pkg::KEY_W-1:0] key,
  output logic                           lt,
  output logic                           eq
);

  logic [skc_pkg::CNT_W-1:0] my_pos;

  assign my_pos = skc_pkg::CNT_W'(idx);
  assign lt = key < probe;
  assign eq = key == probe;

  always_ff @(posedge clk) begin
    if (cmd.ins) begin
      // open the hole at the insert point, move the upper part up
      if (my_pos == cmd.at) begin
        key <= cmd.key;
      end else if (my_pos > cmd.at) begin
        key <= below_key;
      end
    end else if (cmd.rem) begin
      // close the gap by pulling the upper part down
      if (my_pos >= cmd.at) begin
        key <= above_key;
      end
    end
  end

endmodule

### hdl/sorted_key_set_table.sv
// ----------------------------------------------------------------------------
// sorted_key_set_table - ordered set of signed keys in a chain of cells
// Insert, find, remove and read-by-position over up to DEPTH sorted keys.
// ----------------------------------------------------------------------------
//
//  channel | role   | payload
//  --------+--------+-------------------------------------------------------
//  req     | sink   | opcode[1:0], key[31:0] signed, position[3:0]
//  rsp     | source | status[2:0], key_out[31:0], key_position[3:0],
//          |        | entry_count[4:0]
//
// Each request runs through S_IDLE and S_EXEC: the accept edge captures the
// compare flags of all cells against the key; the resolving edge in S_EXEC
// resolves the operation, shifts the chain and loads the response register.
// A request is taken only while no other one is in work.
// If the response register is still held by a stalled sink, resolution waits.
// Reset clears the count and the control; cell keys are not reset, since no
// cell at or above the count is ever read.
module sorted_key_set_table (
  input  logic       clk,
  input  logic       rst,
  skc_req_if.sink    req,
  skc_rsp_if.source  rsp
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state;

  // latched request
  logic [1:0]                       req_op;
  logic signed [skc_pkg::KEY_W-1:0] req_key;
  logic [skc_pkg::POS_W-1:0]        req_pos;
  logic [skc_pkg::DEPTH-1:0]        lt_vec;
  logic [skc_pkg::DEPTH-1:0]        eq_vec;

  logic [skc_pkg::CNT_W-1:0]        count;
  logic [skc_pkg::CNT_W-1:0]        count_next;

  // cell chain
  logic signed [skc_pkg::KEY_W-1:0] cell_key [skc_pkg::DEPTH];
  logic [skc_pkg::DEPTH-1:0]        cell_lt;
  logic [skc_pkg::DEPTH-1:0]        cell_eq;
  logic [skc_pkg::DEPTH-1:0]        cell_used;
  skc_pkg::cell_cmd_t               cmd;

  // resolution
  logic [skc_pkg::CNT_W-1:0]        ins_at;
  logic                             hit;
  logic                             resolve;
  logic                             accept;
  logic [2:0]                       status_next;
  logic signed [skc_pkg::KEY_W-1:0] key_out_next;
  logic [skc_pkg::POS_W-1:0]        pos_next;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign resolve   = (state == S_EXEC) && (!rsp.valid || rsp.ready);

  for (genvar i = 0; i < skc_pkg::DEPTH; i++) begin : g_cell
    logic signed [skc_pkg::KEY_W-1:0] below;
    logic signed [skc_pkg::KEY_W-1:0] above;

    if (i == 0) begin : g_head
      assign below = cell_key[i];
    end else begin : g_mid
      assign below = cell_key[i-1];
    end
    if (i == skc_pkg::DEPTH - 1) begin : g_tail
      assign above = cell_key[i];
    end else begin : g_body
      assign above = cell_key[i+1];
    end

    assign cell_used[i] = skc_pkg::CNT_W'(i) < count;

    skc_cell u_cell (
      .clk       (clk),
      .idx       (skc_pkg::IDX_W'(i)),
      .cmd       (cmd),
      .probe     (req.key),
      .below_key (below),
      .above_key (above),
      .key       (cell_key[i]),
      .lt        (cell_lt[i]),
      .eq        (cell_eq[i])
    );
  end

  // Keys are ascending, so the used cells below the key form a run from the
  // head; the insert point is the first cell outside that run.
  always_comb begin
    ins_at = skc_pkg::CNT_W'(skc_pkg::DEPTH);
    for (int i = skc_pkg::DEPTH - 1; i >= 0; i--) begin
      if (!lt_vec[i]) begin
        ins_at = skc_pkg::CNT_W'(i);
      end
    end
  end

  assign hit = |eq_vec;

  // decide the operation's outcome and the chain command
  always_comb begin
    cmd          = '0;
    cmd.at       = ins_at;
    cmd.key      = req_key;
    count_next   = count;
    status_next  = skc_pkg::ST_OK;
    key_out_next = req_key;
    pos_next     = '0;
    case (req_op)
      skc_pkg::OP_INSERT: begin
        if (hit) begin
          status_next = skc_pkg::ST_DUP;
          pos_next    = skc_pkg::POS_W'(ins_at);
        end else if (count == skc_pkg::CNT_W'(skc_pkg::DEPTH)) begin
          status_next = skc_pkg::ST_FULL;
        end else begin
          cmd.ins    = resolve;
          count_next = count + 1'b1;
          pos_next   = skc_pkg::POS_W'(ins_at);
        end
      end
      skc_pkg::OP_FIND: begin
        if (hit) begin
          pos_next = skc_pkg::POS_W'(ins_at);
        end else begin
          status_next = skc_pkg::ST_NOTFOUND;
        end
      end
      skc_pkg::OP_REMOVE: begin
        if (hit) begin
          cmd.rem    = resolve;
          count_next = count - 1'b1;
          pos_next   = skc_pkg::POS_W'(ins_at);
        end else begin
          status_next = skc_pkg::ST_NOTFOUND;
        end
      end
      default: begin
        pos_next = req_pos;
        if (int'(req_pos) < int'(count)) begin
          key_out_next = cell_key[skc_pkg::IDX_W'(req_pos)];
        end else begin
          status_next  = skc_pkg::ST_RANGE;
          key_out_next = '0;
        end
      end
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (accept) begin
        state <= S_EXEC;
      end else if (resolve) begin
        state <= S_IDLE;
        count <= count_next;
      end
      // a new response replaces one leaving at this edge
      if (resolve) begin
        rsp.valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  // payload: capture the request with the cell flags, load the response
  always_ff @(posedge clk) begin
    if (accept) begin
      req_op  <= req.opcode;
      req_key <= req.key;
      req_pos <= req.position;
      lt_vec  <= cell_lt & cell_used;
      eq_vec  <= cell_eq & cell_used;
    end
    if (resolve) begin
      rsp.status       <= status_next;
      rsp.key_out      <= key_out_next;
      rsp.key_position <= pos_next;
      rsp.entry_count  <= skc_pkg::OUT_CNT_W'(count_next);
    end
  end

endmodule

### hdl/skc_checker.sv
// ----------------------------------------------------------------------------
// skc_checker - port-level checks for the sorted key set table
// Watches the request and response channels of the top level.
// ----------------------------------------------------------------------------
module skc_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [2:0]  status,
  input logic [31:0] key_out,
  input logic [3:0]  key_position,
  input logic [4:0]  entry_count
);

  // one request in work at a time
  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while another is in work");

  // a stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(key_out)
      && $stable(key_position) && $stable(entry_count))
    else $error("stalled response changed");

  // full is reported only with the table at capacity
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == skc_pkg::ST_FULL
      |-> entry_count == skc_pkg::OUT_CNT_W'(skc_pkg::DEPTH))
    else $error("full status with spare room");

  // out of range read reports a zero key and a count not above the position
  a_range_read: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == skc_pkg::ST_RANGE
      |-> key_out == '0 && entry_count <= {1'b0, key_position})
    else $error("bad out of range response");

endmodule

bind sorted_key_set_table skc_checker u_skc_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .status       (rsp.status),
  .key_out      (rsp.key_out),
  .key_position (rsp.key_position),
  .entry_count  (rsp.entry_count)
);

### verif/skc_table_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// skc_table_checker - response checker for the sorted key set table
// Watches both channels, keeps a shadow of the sorted key table, predicts the
// response of every accepted request and compares each response field.
// ----------------------------------------------------------------------------
module skc_table_checker (
  input  logic clk,
  input  logic rst,
  skc_req_if   req,
  skc_rsp_if   rsp,
  output int   pending_count,
  output int   fail_count
);

  typedef struct packed {
    logic [2:0]                       status;
    logic signed [skc_pkg::KEY_W-1:0] key;
    logic [skc_pkg::POS_W-1:0]        pos;
    logic [skc_pkg::OUT_CNT_W-1:0]    count;
  } table_rsp_t;

  logic signed [skc_pkg::KEY_W-1:0] shadow_keys [skc_pkg::DEPTH];
  int                               shadow_count;
  table_rsp_t                       expected_rsp_q [$];
  table_rsp_t                       want;
  int                               rsp_index;

  initial begin
    for (int i = 0; i < skc_pkg::DEPTH; i++) shadow_keys[i] = '0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] exp_val);
    if (got !== exp_val)
      report_mismatch($sformatf("response %0d %s got 0x%0h, want 0x%0h",
                                rsp_index, name, got, exp_val));
  endtask

  // Apply one request to the shadow table and return the response it earns.
  function automatic table_rsp_t apply_table_op(
      input logic [1:0] op,
      input logic signed [skc_pkg::KEY_W-1:0] key,
      input logic [skc_pkg::POS_W-1:0] pos);
    table_rsp_t r;
    int         below;
    logic       hit;
    below    = 0;
    hit      = 1'b0;
    r.status = skc_pkg::ST_OK;
    r.key    = key;
    r.pos    = '0;
    for (int i = 0; i < shadow_count; i++) begin
      if (shadow_keys[i] < key) below++;
      else if (shadow_keys[i] == key) hit = 1'b1;
    end
    case (op)
      skc_pkg::OP_INSERT: begin
        if (hit) begin
          r.status = skc_pkg::ST_DUP;
          r.pos    = below[skc_pkg::POS_W-1:0];
        end else if (shadow_count >= skc_pkg::DEPTH) begin
          r.status = skc_pkg::ST_FULL;
        end else begin
          for (int i = shadow_count; i > below; i--) shadow_keys[i] = shadow_keys[i-1];
          shadow_keys[below] = key;
          shadow_count++;
          r.pos = below[skc_pkg::POS_W-1:0];
        end
      end
      skc_pkg::OP_FIND: begin
        if (hit) r.pos = below[skc_pkg::POS_W-1:0];
        else r.status = skc_pkg::ST_NOTFOUND;
      end
      skc_pkg::OP_REMOVE: begin
        if (hit) begin
          for (int i = below; i + 1 < shadow_count; i++) shadow_keys[i] = shadow_keys[i+1];
          shadow_count--;
          r.pos = below[skc_pkg::POS_W-1:0];
        end else begin
          r.status = skc_pkg::ST_NOTFOUND;
        end
      end
      default: begin
        r.pos = pos;
        if (int'(pos) < shadow_count) begin
          r.key = shadow_keys[pos];
        end else begin
          r.status = skc_pkg::ST_RANGE;
          r.key    = '0;
        end
      end
    endcase
    r.count = shadow_count[skc_pkg::OUT_CNT_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      shadow_count = 0;
      expected_rsp_q.delete();
      fail_count = 0;
      rsp_index = 0;
      pending_count <= 0;
    end else begin
      // A response at this edge belongs to an older request: check it first.
      if (rsp.valid && rsp.ready) begin
        if (expected_rsp_q.size() == 0) begin
          report_mismatch($sformatf("response %0d arrived with none expected", rsp_index));
        end else begin
          want = expected_rsp_q.pop_front();
          check_field("status", 32'(rsp.status), 32'(want.status));
          check_field("key_out", rsp.key_out, want.key);
          check_field("key_position", 32'(rsp.key_position), 32'(want.pos));
          check_field("entry_count", 32'(rsp.entry_count), 32'(want.count));
        end
        rsp_index++;
      end
      if (req.valid && req.ready)
        expected_rsp_q.push_back(apply_table_op(req.opcode, req.key, req.position));
      pending_count <= expected_rsp_q.size();
    end
  end

endmodule

### verif/tb_sorted_key_set_table.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sorted_key_set_table - testbench for the sorted key set table
// Drives a directed set of requests followed by random phases that fill,
// churn and drain the table, with random stalls on both channels; a checker
// beside the block predicts and compares every response.
// ----------------------------------------------------------------------------
module tb_sorted_key_set_table;

  localparam int PHASES        = 10;
  localparam int PHASE_ITEMS   = 155;
  // Longest correct stretch with no handshake is a sender gap plus a sink
  // stall plus the accept and resolve steps of the block; allow far more than that.
  localparam int IDLE_LIMIT    = 2000;
  localparam int DRAIN_CYCLES  = 8;

  localparam logic signed [skc_pkg::KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [skc_pkg::KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;
  localparam int KEY_SPAN = 23;

  // Operation mix of a random phase.
  typedef enum logic [1:0] {MIX_FILL, MIX_CHURN, MIX_DRAIN} phase_mix_t;

  logic clk;
  logic rst;

  skc_req_if req_ch ();
  skc_rsp_if rsp_ch ();

  int   pending_count;
  int   fail_count;
  logic sender_stalls;  // sender may insert gaps
  logic quiet_tail;     // final stretch: no stalls on either side
  int   quiet_cycles;

  sorted_key_set_table dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  skc_table_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .req           (req_ch),
    .rsp           (rsp_ch),
    .pending_count (pending_count),
    .fail_count    (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: end the run if no request and no response moves for too long.
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
      $display("FAIL sorted_key_set_table");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Sink side: hold ready high for a random stretch, or drop it for a random
  // stretch. Keep it high for good once the quiet tail starts.
  initial begin
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (quiet_tail || $urandom_range(0, 3) != 0) begin
        rsp_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end else begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
    end
  end

  // Present one request and hold it until the block takes it. A gap, when
  // chosen, drops valid first; with no gap valid stays high across requests.
  task automatic send_request(input logic [1:0] op,
                              input logic signed [skc_pkg::KEY_W-1:0] key,
                              input logic [skc_pkg::POS_W-1:0] pos);
    if (sender_stalls && !quiet_tail && $urandom_range(0, 7) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.opcode   <= op;
    req_ch.key      <= key;
    req_ch.position <= pos;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  // Drop valid and wait for every outstanding response. The first edge lets
  // the checker count the request taken at the last edge.
  task automatic wait_all_responses();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  // Keys cluster in a narrow window above the base so that finds, removes and
  // duplicates hit often; now and then a fully random key covers every bit.
  function automatic logic signed [skc_pkg::KEY_W-1:0] pick_key(
      input logic signed [skc_pkg::KEY_W-1:0] base);
    logic signed [skc_pkg::KEY_W-1:0] k;
    if ($urandom_range(0, 9) == 0) k = $urandom;
    else k = base + skc_pkg::KEY_W'($urandom_range(0, KEY_SPAN));
    return k;
  endfunction

  function automatic logic [1:0] pick_op(input phase_mix_t mix);
    int   r;
    int   ins_w;
    int   find_w;
    int   rem_w;
    logic [1:0] op;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_FILL:  begin ins_w = 60; find_w = 15; rem_w = 10; end
      MIX_CHURN: begin ins_w = 30; find_w = 25; rem_w = 25; end
      default:   begin ins_w = 15; find_w = 20; rem_w = 45; end
    endcase
    if (r < ins_w) op = skc_pkg::OP_INSERT;
    else if (r < ins_w + find_w) op = skc_pkg::OP_FIND;
    else if (r < ins_w + find_w + rem_w) op = skc_pkg::OP_REMOVE;
    else op = skc_pkg::OP_READ;
    return op;
  endfunction

  initial begin
    phase_mix_t                       mix;
    logic signed [skc_pkg::KEY_W-1:0] base;
    // Drive every block input to a known value from time zero.
    rst             <= 1'b1;
    req_ch.valid    <= 1'b0;
    req_ch.opcode   <= skc_pkg::OP_INSERT;
    req_ch.key      <= '0;
    req_ch.position <= '0;
    sender_stalls   = 1'b1;
    quiet_tail      = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed requests: empty table, key extremes, sign boundary, duplicate,
    // absent keys, reads inside and beyond the count, removes at both ends.
    send_request(skc_pkg::OP_READ, '0, 4'd0);          // read of an empty table
    send_request(skc_pkg::OP_FIND, 32'sd5, '0);        // find in an empty table
    send_request(skc_pkg::OP_REMOVE, 32'sd5, '0);      // remove from an empty table
    send_request(skc_pkg::OP_INSERT, KEY_MAX, '0);
    send_request(skc_pkg::OP_INSERT, KEY_MIN, '0);
    send_request(skc_pkg::OP_INSERT, 32'sd0, '0);
    send_request(skc_pkg::OP_INSERT, -32'sd1, '0);
    send_request(skc_pkg::OP_INSERT, 32'sd1, '0);
    send_request(skc_pkg::OP_INSERT, -32'sd1, '0);     // duplicate insert
    send_request(skc_pkg::OP_FIND, KEY_MAX, '0);
    send_request(skc_pkg::OP_FIND, KEY_MIN, '0);
    send_request(skc_pkg::OP_FIND, 32'sd2, '0);        // absent key
    send_request(skc_pkg::OP_READ, 32'sh5A5A_A5A5, 4'd0);
    send_request(skc_pkg::OP_READ, '0, 4'd4);          // last held key
    send_request(skc_pkg::OP_READ, '0, 4'd5);          // just past the count
    send_request(skc_pkg::OP_READ, '0, 4'd15);
    send_request(skc_pkg::OP_REMOVE, 32'sd0, '0);      // middle of the table
    send_request(skc_pkg::OP_REMOVE, KEY_MIN, '0);     // head
    send_request(skc_pkg::OP_REMOVE, KEY_MAX, '0);     // tail
    send_request(skc_pkg::OP_REMOVE, KEY_MAX, '0);     // already gone
    send_request(skc_pkg::OP_READ, '0, 4'd1);
    send_request(skc_pkg::OP_INSERT, 32'sh7FFF_FFFE, '0);
    wait_all_responses();

    // Random phases. Rotate fill, churn and drain mixes over windows near the
    // negative extreme, the sign boundary, the positive extreme and random
    // places; fill phases run into the full table. Pause for all responses
    // at the end of each phase. The phase with index 4 runs without sender gaps,
    // and the last one runs with no stalls at all.
    for (int ph = 0; ph < PHASES; ph++) begin
      mix = phase_mix_t'(ph % 3);
      case (ph % 4)
        0:       base = KEY_MIN;
        1:       base = -32'sd12;
        2:       base = KEY_MAX - skc_pkg::KEY_W'(KEY_SPAN);
        default: base = $urandom;
      endcase
      sender_stalls = (ph != 4);
      quiet_tail    = (ph == PHASES - 1);
      for (int n = 0; n < PHASE_ITEMS; n++)
        send_request(pick_op(mix), pick_key(base),
                     skc_pkg::POS_W'($urandom_range(0, 15)));
      wait_all_responses();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS sorted_key_set_table");
    end else begin
      $display("FAIL sorted_key_set_table");
    end
    $finish;
  end

endmodule
